// File: design/swrm_pkg.sv
`timescale 1ns / 1ps
package swrm_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int WORKERS    = 4;

	localparam int RIDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W   = $clog2(RING_DEPTH + 1);
	localparam int WSEL_W   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int RAM_DEPTH = WORKERS * RING_DEPTH;
	localparam int ADDR_W   = $clog2(RAM_DEPTH);

	localparam int WORD_W   = 64;
	localparam int ENTRY_W  = 2 * WORD_W;
	localparam int PROD_W   = WORD_W + 10;
	localparam int QBIT_W   = 6;

	localparam logic [9:0] MS_PER_S = 10'd1000;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic push;
		logic start;
		logic ev;
		logic mul;
		logic zero;
		logic sat;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_end;
		logic stop;
		logic ok;
		logic sat;
		logic div_last;
		logic out_busy;
	} status_t;

endpackage

// File: design/swrm_req_if.sv
`timescale 1ns / 1ps
interface swrm_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [1:0]  worker;
	logic [63:0] count_value;
	logic [63:0] time_ms;
	logic [31:0] window_ms;

	modport source (output valid, op, worker, count_value, time_ms, window_ms, input ready);
	modport sink (input valid, op, worker, count_value, time_ms, window_ms, output ready);
endinterface

// File: design/swrm_rsp_if.sv
`timescale 1ns / 1ps
interface swrm_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] rate_q16;
	logic        rate_valid;

	modport source (output valid, rate_q16, rate_valid, input ready);
	modport sink (input valid, rate_q16, rate_valid, output ready);
endinterface

// File: design/swrm_ram.sv
`timescale 1ns / 1ps
module swrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/swrm_ctrl.sv
`timescale 1ns / 1ps
module swrm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_op,
	input  swrm_pkg::status_t sts,
	output logic              idle,
	output swrm_pkg::cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_CHK,
		S_PRE,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_op == swrm_pkg::OP_PUSH) begin
						cmd.push = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_RD;
					end
				end
			end
			S_RD: begin
				state_d = sts.walk_end ? S_CHK : S_EV;
			end
			S_EV: begin
				cmd.ev  = 1'b1;
				state_d = sts.stop ? S_CHK : S_RD;
			end
			S_CHK: begin
				if (sts.ok) begin
					cmd.mul = 1'b1;
					state_d = S_PRE;
				end else begin
					cmd.zero = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_PRE: begin
				if (sts.sat) begin
					cmd.sat = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: design/swrm_dp.sv
`timescale 1ns / 1ps
module swrm_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  swrm_pkg::cmd_t    cmd,
	output swrm_pkg::status_t sts,
	input  logic [1:0]        worker,
	input  logic [63:0]       count_value,
	input  logic [63:0]       time_ms,
	input  logic [31:0]       window_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       rate_q16,
	output logic              rate_valid
);
	localparam int RIDX_W = swrm_pkg::RIDX_W;
	localparam int FILL_W = swrm_pkg::FILL_W;
	localparam int WSEL_W = swrm_pkg::WSEL_W;
	localparam int ADDR_W = swrm_pkg::ADDR_W;
	localparam int PROD_W = swrm_pkg::PROD_W;

	logic [RIDX_W-1:0] top_q  [swrm_pkg::WORKERS];
	logic [FILL_W-1:0] fill_q [swrm_pkg::WORKERS];

	logic              in_wok;
	logic [WSEL_W-1:0] in_wsel;
	logic [RIDX_W-1:0] in_top;
	logic [ADDR_W-1:0] waddr;

	logic              wok_q;
	logic [WSEL_W-1:0] wsel_q;
	logic [63:0]       now_q;
	logic [31:0]       win_q;
	logic [FILL_W-1:0] step_q;
	logic              full_q;
	logic [63:0]       e_cnt_q, e_stamp_q, l_cnt_q, l_stamp_q;

	logic [RIDX_W-1:0] cur_top;
	logic [FILL_W:0]   ridx_w;
	logic [RIDX_W-1:0] ridx;
	logic [ADDR_W-1:0] raddr;
	logic [127:0]      rdata;
	logic [63:0]       s_stamp, s_cnt;
	logic              s_empty, s_out;

	logic [PROD_W-1:0] prod_q;
	logic [63:0]       dt_q;
	logic [63:0]       r_q, lo_q, quo_q;
	logic [5:0]        bit_q;
	logic [64:0]       r_sh;
	logic              take;
	logic [63:0]       r_nx;
	logic [63:0]       q_nx;

	logic [63:0]       res_q;
	logic              resv_q;
	logic              out_valid_q;
	logic [63:0]       out_rate_q;
	logic              out_rv_q;

	assign in_wok  = (32'(worker) < swrm_pkg::WORKERS);
	assign in_wsel = WSEL_W'(worker);
	assign in_top  = top_q[in_wsel];
	assign waddr   = ADDR_W'(ADDR_W'(in_wsel) * ADDR_W'(swrm_pkg::RING_DEPTH)) + ADDR_W'(in_top);

	assign cur_top = top_q[wsel_q];
	assign ridx_w  = ((FILL_W+1)'(cur_top) >= (FILL_W+1)'(step_q))
		? (FILL_W+1)'(cur_top) - (FILL_W+1)'(step_q)
		: (FILL_W+1)'(cur_top) + (FILL_W+1)'(swrm_pkg::RING_DEPTH) - (FILL_W+1)'(step_q);
	assign ridx  = ridx_w[RIDX_W-1:0];
	assign raddr = ADDR_W'(ADDR_W'(wsel_q) * ADDR_W'(swrm_pkg::RING_DEPTH)) + ADDR_W'(ridx);

	swrm_ram #(
		.WIDTH(swrm_pkg::ENTRY_W),
		.DEPTH(swrm_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push && in_wok),
		.waddr(waddr),
		.wdata({count_value, time_ms}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign s_stamp = rdata[63:0];
	assign s_cnt   = rdata[127:64];
	assign s_empty = (s_stamp == 64'd0);
	assign s_out   = ((now_q - s_stamp) > {32'd0, win_q});

	assign sts.walk_end = !wok_q || (step_q > fill_q[wsel_q])
		|| (step_q == FILL_W'(swrm_pkg::RING_DEPTH));
	assign sts.stop     = s_empty || s_out;
	assign sts.ok       = full_q && (e_stamp_q != 64'd0) && (l_stamp_q != 64'd0)
		&& (l_stamp_q != e_stamp_q);
	assign sts.sat      = {38'd0, prod_q[PROD_W-1:48]} >= dt_q;
	assign sts.div_last = (bit_q == 6'd0);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign r_sh = {r_q, lo_q[63]};
	assign take = r_sh[64] || (r_sh[63:0] >= dt_q);
	assign r_nx = take ? r_sh[63:0] - dt_q : r_sh[63:0];
	assign q_nx = {quo_q[62:0], take};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			wok_q     <= in_wok;
			wsel_q    <= in_wsel;
			now_q     <= time_ms;
			win_q     <= window_ms;
			step_q    <= FILL_W'(1);
			full_q    <= 1'b0;
			e_stamp_q <= 64'd0;
			l_stamp_q <= 64'd0;
		end
		if (cmd.ev && !s_empty) begin
			if (l_stamp_q == 64'd0) begin
				l_stamp_q <= s_stamp;
				l_cnt_q   <= s_cnt;
			end
			if (s_out) begin
				full_q <= 1'b1;
			end else begin
				e_stamp_q <= s_stamp;
				e_cnt_q   <= s_cnt;
				step_q    <= step_q + FILL_W'(1);
			end
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(l_cnt_q - e_cnt_q) * PROD_W'(swrm_pkg::MS_PER_S);
			dt_q   <= l_stamp_q - e_stamp_q;
		end
		if (cmd.div_init) begin
			r_q   <= {38'd0, prod_q[PROD_W-1:48]};
			lo_q  <= {prod_q[47:0], 16'd0};
			quo_q <= 64'd0;
			bit_q <= 6'd63;
		end
		if (cmd.div_step) begin
			r_q   <= r_nx;
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= q_nx;
			bit_q <= bit_q - 6'd1;
			if (bit_q == 6'd0) begin
				res_q  <= q_nx;
				resv_q <= 1'b1;
			end
		end
		if (cmd.zero) begin
			res_q  <= 64'd0;
			resv_q <= 1'b0;
		end
		if (cmd.sat) begin
			res_q  <= '1;
			resv_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_rate_q <= res_q;
			out_rv_q   <= resv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int k = 0; k < swrm_pkg::WORKERS; k++) begin
				top_q[k]  <= '0;
				fill_q[k] <= '0;
			end
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push && in_wok) begin
				top_q[in_wsel] <= (in_top == RIDX_W'(swrm_pkg::RING_DEPTH - 1))
					? '0 : in_top + RIDX_W'(1);
				if (fill_q[in_wsel] != FILL_W'(swrm_pkg::RING_DEPTH)) begin
					fill_q[in_wsel] <= fill_q[in_wsel] + FILL_W'(1);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign rate_q16   = out_rate_q;
	assign rate_valid = out_rv_q;
endmodule

// File: design/sliding_window_rate_meter.sv
`timescale 1ns / 1ps
// sliding window rate meter
// req channel: op 0 pushes (count_value, time_ms) into the ring of one worker,
// op 1 queries the rate of that worker over window_ms ending at time_ms.
// rsp channel: one item per query, none per push; rate_q16 is events per
// second in unsigned q16, saturating, and rate_valid flags a covered window.
// a push is written straight from the idle state. a query walks back through
// the ring one sample at a time (ram read, then compare), up to ring depth
// minus one samples, then does the scaling multiply and then runs the
// one-bit-per-cycle divider to form the q16 quotient.
// requests are taken only while the controller is idle; a finished result
// sits in the output register until the receiver takes it, and the next
// request is accepted meanwhile. a query that finishes while that register
// is still held waits until the receiver drains it.
// reset clears the write pointers, fill counts and the output valid; ring
// slots never written since reset read as empty through the fill counts,
// so no clearing pass is needed.
module sliding_window_rate_meter (
	input  logic       clk,
	input  logic       arst_n,
	swrm_req_if.sink   req,
	swrm_rsp_if.source rsp
);
	swrm_pkg::cmd_t    cmd;
	swrm_pkg::status_t sts;
	logic              idle;

	assign req.ready = idle;

	swrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_op   (req.op),
		.sts      (sts),
		.idle     (idle),
		.cmd      (cmd)
	);

	swrm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.worker     (req.worker),
		.count_value(req.count_value),
		.time_ms    (req.time_ms),
		.window_ms  (req.window_ms),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.rate_q16   (rsp.rate_q16),
		.rate_valid (rsp.rate_valid)
	);
endmodule
